// ===== rtl/fcca_pkg.sv =====
`timescale 1ns / 1ps
// fcca_pkg: shared constants, codes and types for the FAT cluster chain allocator.
// No dependencies.
package fcca_pkg;

	localparam int TABLE_ENTRIES = 65536;
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
	localparam int VAL_W         = 28;
	localparam int LIMIT_W       = ADDR_W + 1;
	localparam int OP_W          = 2;

	localparam logic [VAL_W-1:0]   END_MARK      = 28'hFFF_FFFF;
	localparam logic [LIMIT_W-1:0] TABLE_END     = LIMIT_W'(TABLE_ENTRIES);
	localparam logic [LIMIT_W-1:0] FIRST_CLUSTER = LIMIT_W'(2);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(TABLE_ENTRIES);
	localparam logic [ADDR_W-1:0]  TAIL_RESET    = ADDR_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_READ  = 2'd1,
		OP_ALLOC = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READW = 5'b00010,
		ST_SRCH  = 5'b00100,
		ST_MARK  = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] index;
		logic [VAL_W-1:0]  value;
		logic              first;
		logic              final_c;
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic [ADDR_W-1:0] granted;
		logic [VAL_W-1:0]  rdata;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

// ===== rtl/fat_cluster_chain_allocator_top.sv =====
`timescale 1ns / 1ps
// Load writes the table and replies; read waits for the registered table data; allocate walks
// entries from the start point, one entry walked per cycle, then marks a final new cluster.
// Throughput: one item at a time; next item accepted once the result is registered.
// Reset: arst_n async, active low; chain tail -> 1, limit -> 65536, table not cleared.
// Depends on fcca_pkg, fcca_table_ram, fcca_engine.
module fat_cluster_chain_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fcca_pkg::LIMIT_W-1:0]  cfg_data,   // cluster_limit
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [47:0]                   s_tdata,    // op, entry_index, entry_value
	input  logic                          s_tuser,    // chain_first
	input  logic                          s_tlast,    // chain_final
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [47:0]                   m_tdata,    // granted_cluster, read_data
	output logic                          m_tuser     // status
);

	logic [fcca_pkg::LIMIT_W-1:0]  limit_q;
	fcca_pkg::cmd_t                cmd;
	fcca_pkg::ram_req_t            ram_req;
	logic [fcca_pkg::VAL_W-1:0]    ram_rdata;
	logic                          res_valid;
	logic                          res_ready;
	fcca_pkg::res_t                res;
	logic                          out_valid_q;
	fcca_pkg::res_t                out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fcca_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	assign cmd.op      = fcca_pkg::op_t'(s_tdata[1:0]);
	assign cmd.index   = s_tdata[17:2];
	assign cmd.value   = s_tdata[45:18];
	assign cmd.first   = s_tuser;
	assign cmd.final_c = s_tlast;

	fcca_table_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	fcca_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.limit     (limit_q),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {4'b0, out_q.rdata, out_q.granted};

endmodule

// ===== rtl/fcca_table_ram.sv =====
`timescale 1ns / 1ps
// fcca_table_ram: cluster table, one write and one registered read per cycle.
// Depends on fcca_pkg.
module fcca_table_ram (
	input  logic                        clk,
	input  fcca_pkg::ram_req_t          req,
	output logic [fcca_pkg::VAL_W-1:0]  rdata
);

	logic [fcca_pkg::VAL_W-1:0] mem [fcca_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== rtl/fcca_engine.sv =====
`timescale 1ns / 1ps
// fcca_engine: command sequencer; load, read back and free-entry search with chain linking.
// Depends on fcca_pkg; drives fcca_table_ram through a ram_req_t.
module fcca_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  fcca_pkg::cmd_t                cmd,
	input  logic [fcca_pkg::LIMIT_W-1:0]  limit,
	output fcca_pkg::ram_req_t            ram_req,
	input  logic [fcca_pkg::VAL_W-1:0]    ram_rdata,
	output logic                          res_valid,
	input  logic                          res_ready,
	output fcca_pkg::res_t                res
);

	fcca_pkg::state_t                state_q;
	logic [fcca_pkg::ADDR_W-1:0]     tail_q;
	logic                            pend_s1;
	logic [fcca_pkg::ADDR_W-1:0]     addr_s1;
	logic [fcca_pkg::LIMIT_W-1:0]    issue_q;
	logic [fcca_pkg::LIMIT_W-1:0]    end_q;
	logic                            link_q;
	logic                            final_q;
	fcca_pkg::res_t                  res_q;

	logic                            hit;
	logic                            can_issue;
	logic [fcca_pkg::LIMIT_W-1:0]    start;
	logic [fcca_pkg::LIMIT_W-1:0]    end_lim;

	assign hit       = pend_s1 && (ram_rdata == '0);
	assign can_issue = issue_q < end_q;
	assign start     = cmd.first ? fcca_pkg::FIRST_CLUSTER
	                             : {1'b0, tail_q} + fcca_pkg::LIMIT_W'(1);
	assign end_lim   = (limit > fcca_pkg::TABLE_END) ? fcca_pkg::TABLE_END : limit;

	assign cmd_ready = (state_q == fcca_pkg::ST_IDLE);
	assign res_valid = (state_q == fcca_pkg::ST_RESP);
	assign res       = res_q;

	always_comb begin
		ram_req = '0;
		unique case (state_q)
			fcca_pkg::ST_IDLE: begin
				if (cmd_valid && cmd.op == fcca_pkg::OP_LOAD) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = cmd.index;
					ram_req.wdata = cmd.value;
				end
				if (cmd_valid && cmd.op == fcca_pkg::OP_READ) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = cmd.index;
				end
			end
			fcca_pkg::ST_SRCH: begin
				if (hit) begin
					// link old tail to the new cluster
					ram_req.we    = link_q;
					ram_req.waddr = tail_q;
					ram_req.wdata = fcca_pkg::VAL_W'(addr_s1);
				end else if (can_issue) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = issue_q[fcca_pkg::ADDR_W-1:0];
				end
			end
			fcca_pkg::ST_MARK: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = addr_s1;
				ram_req.wdata = fcca_pkg::END_MARK;
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcca_pkg::ST_IDLE;
			tail_q  <= fcca_pkg::TAIL_RESET;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				fcca_pkg::ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (cmd_valid) begin
						unique case (cmd.op)
							fcca_pkg::OP_READ:  state_q <= fcca_pkg::ST_READW;
							fcca_pkg::OP_ALLOC: state_q <= fcca_pkg::ST_SRCH;
							default:            state_q <= fcca_pkg::ST_RESP;
						endcase
					end
				end
				fcca_pkg::ST_READW: begin
					state_q <= fcca_pkg::ST_RESP;
				end
				fcca_pkg::ST_SRCH: begin
					if (hit) begin
						pend_s1 <= 1'b0;
						tail_q  <= addr_s1;
						state_q <= final_q ? fcca_pkg::ST_MARK : fcca_pkg::ST_RESP;
					end else if (!can_issue) begin
						pend_s1 <= 1'b0;
						state_q <= fcca_pkg::ST_RESP;
					end else begin
						pend_s1 <= 1'b1;
					end
				end
				fcca_pkg::ST_MARK: begin
					state_q <= fcca_pkg::ST_RESP;
				end
				fcca_pkg::ST_RESP: begin
					if (res_ready) begin
						state_q <= fcca_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fcca_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fcca_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					res_q   <= '0;
					issue_q <= start;
					end_q   <= end_lim;
					link_q  <= !cmd.first && (tail_q > fcca_pkg::TAIL_RESET);
					final_q <= cmd.final_c;
				end
			end
			fcca_pkg::ST_READW: begin
				res_q.rdata <= ram_rdata;
			end
			fcca_pkg::ST_SRCH: begin
				if (hit) begin
					res_q.granted <= addr_s1;
				end else if (!can_issue) begin
					res_q.status <= 1'b1;
				end else begin
					addr_s1 <= issue_q[fcca_pkg::ADDR_W-1:0];
					issue_q <= issue_q + fcca_pkg::LIMIT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/tb_fat_cluster_chain_allocator_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fat_cluster_chain_allocator_top: table loads, reads and chain
// allocations over the stream ports, each reply predicted by an in-bench table shadow.
// Depends on fcca_pkg and the allocator RTL.
module tb_fat_cluster_chain_allocator_top;
	import fcca_pkg::*;

	localparam int WORK_SPAN = 256;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data  = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [47:0]        s_tdata   = '0;    // op, entry_index, entry_value, zero pad
	logic               s_tuser   = 1'b0;  // chain_first
	logic               s_tlast   = 1'b0;  // chain_final
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [47:0]        m_tdata;           // granted_cluster, read_data, zero pad
	logic               m_tuser;           // status

	logic [VAL_W-1:0] fat_table [TABLE_ENTRIES];
	bit               entry_written [TABLE_ENTRIES];
	int               written_idx[$];
	int               tail_cluster = int'(TAIL_RESET);
	int               limit_shadow = int'(LIMIT_RESET);

	res_t expected_replies[$];
	int   errors = 0;
	int   replies_seen = 0;
	int   n_load = 0, n_read = 0, n_alloc = 0, n_no_space = 0;
	int   sink_hold = 0, sink_gap = 0;
	int   src_idle_pct = 0, sink_idle_pct = 0;

	fat_cluster_chain_allocator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit coin();
		return $urandom_range(0, 1) != 0;
	endfunction

	function automatic int search_end();
		return (limit_shadow > TABLE_ENTRIES) ? TABLE_ENTRIES : limit_shadow;
	endfunction

	// first never-written entry an allocation would touch, -1 if none
	function automatic int first_unwritten_on_path(input bit chain_start);
		int n, stop;
		stop = search_end();
		n = chain_start ? 2 : tail_cluster + 1;
		while (n < stop) begin
			if (!entry_written[n])
				return n;
			if (fat_table[n] == '0)
				return -1;
			n++;
		end
		return -1;
	endfunction

	function automatic res_t predict_cluster_op(input cmd_t c);
		res_t r;
		int   n, stop;
		r = '0;
		case (c.op)
			OP_LOAD: begin
				if (!entry_written[c.index])
					written_idx.push_back(int'(c.index));
				entry_written[c.index] = 1'b1;
				fat_table[c.index] = c.value;
				n_load++;
			end
			OP_READ: begin
				r.rdata = fat_table[c.index];
				n_read++;
			end
			OP_ALLOC: begin
				n_alloc++;
				stop = search_end();
				n = c.first ? 2 : tail_cluster + 1;
				while (n < stop && fat_table[n] != '0)
					n++;
				if (n >= stop) begin
					r.status = 1'b1;
					n_no_space++;
				end else begin
					if (!c.first && tail_cluster > 1)
						fat_table[tail_cluster] = VAL_W'(n);
					if (c.final_c)
						fat_table[n] = END_MARK;
					tail_cluster = n;
					r.granted = n[ADDR_W-1:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_t make_cmd(input op_t op, input int idx, input logic [VAL_W-1:0] val,
			input bit chain_start, input bit chain_end);
		cmd_t c;
		c.op      = op;
		c.index   = idx[ADDR_W-1:0];
		c.value   = val;
		c.first   = chain_start;
		c.final_c = chain_end;
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, c.value, c.index, c.op};
		s_tuser  <= c.first;
		s_tlast  <= c.final_c;
		do @(posedge clk); while (!s_tready);
		expected_replies.push_back(predict_cluster_op(c));
	endtask

	// clears the first never-written entry on the search path so the walk stays defined
	task automatic send_alloc(input bit chain_start, input bit chain_end);
		int gap_idx;
		gap_idx = first_unwritten_on_path(chain_start);
		if (gap_idx >= 0)
			send_cmd(make_cmd(OP_LOAD, gap_idx, '0, coin(), coin()));
		send_cmd(make_cmd(OP_ALLOC, $urandom, VAL_W'($urandom), chain_start, chain_end));
	endtask

	task automatic send_read_written();
		send_cmd(make_cmd(OP_READ, written_idx[$urandom_range(0, written_idx.size() - 1)],
			VAL_W'($urandom), coin(), coin()));
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_cluster_limit(input int v);
		cfg_valid <= 1'b1;
		cfg_data  <= LIMIT_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_shadow = v;
	endtask

	task automatic test_table_setup();
		int k;
		src_idle_pct  = 20;
		sink_idle_pct = 20;
		for (k = 0; k < WORK_SPAN; k++)
			send_cmd(make_cmd(OP_LOAD, k, '0, 1'b0, 1'b0));
	endtask

	task automatic test_directed_cases();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		send_cmd(make_cmd(OP_NONE, 'hFFFF, 28'hFFF_FFFF, 1'b1, 1'b1));
		send_cmd(make_cmd(OP_LOAD, 'hFFFF, END_MARK, 1'b1, 1'b1));
		send_cmd(make_cmd(OP_READ, 'hFFFF, '0, 1'b0, 1'b0));
		send_cmd(make_cmd(OP_LOAD, 0, 28'h000_0001, 1'b0, 1'b0));
		send_cmd(make_cmd(OP_READ, 0, 28'hFFF_FFFF, 1'b1, 1'b0));
		send_alloc(1'b0, 1'b0);  // no chain yet: search from 2, nothing linked
		send_alloc(1'b0, 1'b1);
		send_cmd(make_cmd(OP_READ, 2, '0, 1'b0, 1'b0));
		send_cmd(make_cmd(OP_READ, 3, '0, 1'b0, 1'b0));
		send_alloc(1'b1, 1'b1);  // folder
		send_alloc(1'b1, 1'b0);
		send_alloc(1'b0, 1'b1);
		drain_replies();
		set_cluster_limit(7);
		send_alloc(1'b0, 1'b0);  // tail is the last entry below the limit
		send_alloc(1'b1, 1'b0);  // all entries from 2 up to the limit in use
		send_cmd(make_cmd(OP_READ, 6, '0, 1'b0, 1'b0));
		drain_replies();
		set_cluster_limit(3);
		send_alloc(1'b1, 1'b1);
		send_alloc(1'b0, 1'b0);
		send_cmd(make_cmd(OP_LOAD, 2, '0, 1'b0, 1'b0));
		send_alloc(1'b1, 1'b1);
		send_cmd(make_cmd(OP_READ, 2, '0, 1'b0, 1'b0));
	endtask

	task automatic test_random_mix(input int count, input int limit,
			input int src_pct, input int sink_pct);
		int k, pick, span;
		drain_replies();
		set_cluster_limit(limit);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		span = (limit_shadow < WORK_SPAN) ? limit_shadow + 2 : WORK_SPAN;
		for (k = 0; k < count; k++) begin
			if (k == count / 2)
				drain_replies();  // sender waits until every reply is back
			pick = $urandom_range(0, 99);
			if (pick < 30)
				send_alloc($urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0);
			else if (pick < 35)
				send_alloc(1'b1, 1'b1);
			else if (pick < 58)
				send_cmd(make_cmd(OP_LOAD, $urandom_range(0, span - 1), '0,
					coin(), coin()));
			else if (pick < 66)
				send_cmd(make_cmd(OP_LOAD, $urandom_range(0, span - 1),
					VAL_W'($urandom_range(1, 'hFFF_FFFF)), 1'b0, 1'b0));
			else if (pick < 73)
				send_cmd(make_cmd(OP_LOAD, $urandom, VAL_W'($urandom),
					coin(), coin()));
			else if (pick < 93)
				send_read_written();
			else
				send_cmd(make_cmd(OP_NONE, $urandom, VAL_W'($urandom),
					coin(), coin()));
		end
	endtask

	// output held off for a long stretch while transfers keep being offered
	task automatic test_backpressure();
		int k;
		drain_replies();
		src_idle_pct = 0;
		sink_hold    = 200;
		for (k = 0; k < 16; k++) begin
			case (k % 4)
				0: send_cmd(make_cmd(OP_LOAD, $urandom_range(2, WORK_SPAN - 1), '0, 1'b0, 1'b0));
				1: send_read_written();
				2: send_alloc(1'b1, 1'b0);
				default: send_alloc(1'b0, 1'b1);
			endcase
		end
		drain_replies();
	endtask

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else if (sink_gap > 0) begin
			m_tready <= 1'b0;
			sink_gap--;
		end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
			m_tready <= 1'b0;
			sink_gap = $urandom_range(0, 8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : reply_check
		res_t want;
		if (m_tvalid && m_tready) begin
			replies_seen++;
			if (expected_replies.size() == 0) begin
				errors++;
				$display("%0t: reply with none expected, status %0b granted %h read_data %h",
					$time, m_tuser, m_tdata[ADDR_W-1:0], m_tdata[ADDR_W+VAL_W-1:ADDR_W]);
			end else begin
				want = expected_replies.pop_front();
				if (m_tuser !== want.status) begin
					errors++;
					$display("%0t: status expected %0b, got %0b", $time, want.status, m_tuser);
				end
				if (m_tdata[ADDR_W-1:0] !== want.granted) begin
					errors++;
					$display("%0t: granted_cluster expected %h, got %h",
						$time, want.granted, m_tdata[ADDR_W-1:0]);
				end
				if (m_tdata[ADDR_W+VAL_W-1:ADDR_W] !== want.rdata) begin
					errors++;
					$display("%0t: read_data expected %h, got %h",
						$time, want.rdata, m_tdata[ADDR_W+VAL_W-1:ADDR_W]);
				end
			end
		end
	end

	initial begin : run
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_setup();
		test_directed_cases();
		test_random_mix(250, int'(LIMIT_RESET), 20, 20);
		test_random_mix(100, 3, 15, 30);
		test_backpressure();
		test_random_mix(200, 16, 0, 25);
		test_random_mix(200, $urandom_range(4, 65536), 30, 10);
		test_random_mix(200, WORK_SPAN, 10, 0);
		test_random_mix(200, 100, 25, 25);
		test_random_mix(150, 65535, 0, 0);
		drain_replies();
		repeat (10) @(posedge clk);
		$display("Checked %0d replies: %0d loads, %0d reads, %0d allocations (%0d without a free",
			replies_seen, n_load, n_read, n_alloc, n_no_space);
		$display("cluster), search limits from 3 to 65536, random idling and a long output stall.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
